### design/mscrc_pkg.sv
// Package for the multi-standard CRC engine.
// Holds the mode codes and the unrolled byte-wide CRC update functions.
// No dependencies.
`timescale 1ns / 1ps

package mscrc_pkg;

	// Mode codes of the crc_mode register; other codes run as CRC-8
	typedef enum logic [2:0] {
		MODE_CRC8   = 3'd0,
		MODE_ARC    = 3'd1,
		MODE_MODBUS = 3'd2,
		MODE_DNP    = 3'd3,
		MODE_CRC32  = 3'd4
	} mode_t;

	localparam int CrcW = 32;

	localparam logic [CrcW-1:0] POLY_ARC   = 32'h0000_A001;
	localparam logic [CrcW-1:0] POLY_DNP   = 32'h0000_A6BC;
	localparam logic [CrcW-1:0] POLY_CRC32 = 32'hEDB8_8320;
	localparam logic [7:0]      POLY_CRC8  = 8'h07;

	localparam logic [CrcW-1:0] MASK_8  = 32'h0000_00FF;
	localparam logic [CrcW-1:0] MASK_16 = 32'h0000_FFFF;
	localparam logic [CrcW-1:0] MASK_32 = 32'hFFFF_FFFF;

	// LSB-first update of one byte, eight shift steps unrolled
	function automatic logic [CrcW-1:0] fold_reflected(input logic [CrcW-1:0] crc_in,
			input logic [7:0] data, input logic [CrcW-1:0] poly);
		logic [CrcW-1:0] c;
		c = crc_in ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// MSB-first CRC-8 update of one byte
	function automatic logic [7:0] fold_crc8(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ POLY_CRC8;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### design/mscrc_fold.sv
// Byte fold of the CRC engine: reload, one-byte update and final xor per mode.
// Purely combinational; depends on mscrc_pkg.
`timescale 1ns / 1ps

module mscrc_fold import mscrc_pkg::*; (
	input  logic [2:0]      mode,
	input  logic [CrcW-1:0] crc_cur,
	input  logic [7:0]      data_byte,
	input  logic            message_start,
	output logic [CrcW-1:0] crc_next,
	output logic [CrcW-1:0] crc_result
);

	logic [CrcW-1:0] mask;
	logic [CrcW-1:0] init_val;
	logic [CrcW-1:0] xor_out;
	logic [CrcW-1:0] poly;
	logic            is_crc8;
	logic [CrcW-1:0] seed;
	logic [CrcW-1:0] folded;

	// per-mode constants
	always_comb begin
		mask     = MASK_16;
		init_val = '0;
		xor_out  = '0;
		poly     = POLY_ARC;
		is_crc8  = 1'b0;
		case (mode)
			MODE_ARC: begin
			end
			MODE_MODBUS: begin
				init_val = MASK_16;
			end
			MODE_DNP: begin
				poly    = POLY_DNP;
				xor_out = MASK_16;
			end
			MODE_CRC32: begin
				mask     = MASK_32;
				init_val = MASK_32;
				xor_out  = MASK_32;
				poly     = POLY_CRC32;
			end
			default: begin
				// CRC-8, also for the unused codes
				mask    = MASK_8;
				is_crc8 = 1'b1;
			end
		endcase
	end

	// reload or narrow the running value, then fold the byte
	always_comb begin
		seed = message_start ? init_val : (crc_cur & mask);
		if (is_crc8) begin
			folded = {24'd0, fold_crc8(seed[7:0], data_byte)};
		end else begin
			folded = fold_reflected(seed, data_byte, poly) & mask;
		end
	end

	assign crc_next   = folded;
	assign crc_result = (folded ^ xor_out) & mask;

endmodule

### design/multi_standard_crc_engine_top.sv
// Top level of the multi-standard CRC engine: input stage, running CRC,
// result register and mode register. Depends on mscrc_pkg and mscrc_fold.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): data_byte with message_start, which
//   reloads the mode's initial value before the byte, and message_end.
//   Output channel (out_valid / out_stall): crc_value, the CRC of the message
//   so far after the final xor (upper bits zero for 8- and 16-bit modes), and
//   final_flag, a copy of message_end. Every item gives exactly one result.
//   Config channel (cfg_valid / cfg_ready): writes crc_mode (0 CRC-8,
//   1 CRC-16/ARC, 2 CRC-16/MODBUS, 3 CRC-16/DNP, 4 CRC-32, others CRC-8).
//   cfg_ready is always high; write only while no item is in flight.
// Timing
//   An accepted item sits in the input register, is folded combinationally
//   and lands in the result register once the receiver does not stall it.
//   One byte per cycle sustained while the receiver does not stall; the
//   running CRC register closes the only loop, one unrolled 8-bit fold deep.
// Reset and stall
//   Reset empties both registers, clears the running CRC to zero and the mode
//   to CRC-8. While the receiver stalls, the result holds; one more item can
//   wait in the input register, after which in_stall rises.

module multi_standard_crc_engine_top import mscrc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	// input items
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      data_byte,
	input  logic            message_start,
	input  logic            message_end,
	// result items
	output logic            out_valid,
	input  logic            out_stall,
	output logic [CrcW-1:0] crc_value,
	output logic            final_flag,
	// mode register write
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      crc_mode
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            start_s1;
	logic            end_s1;
	logic            out_valid_q;
	logic [CrcW-1:0] crc_value_q;
	logic            final_q;
	logic [CrcW-1:0] crc_q;
	logic [2:0]      mode_q;
	logic            advance;
	logic            load_s1;
	logic [CrcW-1:0] crc_next;
	logic [CrcW-1:0] crc_result;

	// handshake control
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign load_s1   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			crc_q       <= '0;
			mode_q      <= MODE_CRC8;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				crc_q       <= crc_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				mode_q <= crc_mode;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= data_byte;
			start_s1 <= message_start;
			end_s1   <= message_end;
		end
	end

	// byte fold
	mscrc_fold u_fold (
		.mode          (mode_q),
		.crc_cur       (crc_q),
		.data_byte     (byte_s1),
		.message_start (start_s1),
		.crc_next      (crc_next),
		.crc_result    (crc_result)
	);

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			crc_value_q <= crc_result;
			final_q     <= end_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign crc_value  = crc_value_q;
	assign final_flag = final_q;

	// checks
	a_fold_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("folded item did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !advance)
		else $error("result overwritten while stalled");

	a_crc8_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_q == MODE_CRC8 || mode_q > MODE_CRC32) |=> crc_q[CrcW-1:8] == '0)
		else $error("CRC-8 running value has upper bits set");

	a_crc16_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_q == MODE_ARC || mode_q == MODE_MODBUS || mode_q == MODE_DNP)
		|=> crc_q[CrcW-1:16] == '0)
		else $error("CRC-16 running value has upper bits set");

endmodule
